FILE: rtl/cfr_pkg.sv
// Shared types, codes and field positions for the clock frame replacement block.
package cfr_pkg;

    localparam int CMD_W    = 2;
    localparam int IDX_W    = 6;
    localparam int PTAG_W   = 20;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;

    localparam int S_DATA_W     = 32;
    localparam int IN_IDX_LO    = 0;
    localparam int IN_TAG_LO    = IN_IDX_LO + IDX_W;
    localparam int IN_KIND_LO   = IN_TAG_LO + PTAG_W;
    localparam int IN_WRITE_BIT = IN_KIND_LO + KIND_W;
    localparam int IN_PIN_BIT   = IN_WRITE_BIT + 1;

    localparam int M_DATA_W        = 32;
    localparam int OUT_EVICTED_BIT = IDX_W;
    localparam int OUT_TAG_LO      = OUT_EVICTED_BIT + 1;
    localparam int OUT_WB_BIT      = OUT_TAG_LO + PTAG_W;
    localparam int OUT_USED_W      = OUT_WB_BIT + 1;

    localparam int ENT_VALID    = 0;
    localparam int ENT_ACCESSED = 1;
    localparam int ENT_DIRTY    = 2;
    localparam int ENT_PINNED   = 3;
    localparam int ENT_KIND_LO  = 4;
    localparam int ENT_TAG_LO   = ENT_KIND_LO + KIND_W;

    localparam logic [KIND_W-1:0] KIND_ANON = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BIN  = 2'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_REF   = 2'd2,
        CMD_PIN   = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK         = 2'd0,
        STAT_ALL_PINNED = 2'd1,
        STAT_NOT_VALID  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_SWEEP,
        S_TARGET,
        S_DELIVER
    } state_t;

    typedef struct packed {
        cmd_t              command;
        logic [IDX_W-1:0]  frame_index;
        logic [PTAG_W-1:0] page_tag;
        logic [KIND_W-1:0] page_kind;
        logic              is_write;
        logic              pin_value;
    } cfr_item_t;

    typedef struct packed {
        status_t           status;
        logic [IDX_W-1:0]  granted_frame;
        logic              evicted;
        logic [PTAG_W-1:0] evicted_tag;
        logic              write_back;
    } cfr_result_t;

endpackage

FILE: rtl/cfr_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module cfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/cfr_ctrl.sv
// Command sequencer: reads, modifies and writes back frame slots, runs the scan and the clock sweep.
module cfr_ctrl
    import cfr_pkg::*;
#(
    parameter int FRAME_COUNT = 64,
    parameter int TAG_BITS = 20,
    localparam int SLOT_W = $clog2(FRAME_COUNT),
    localparam int ENT_W = ENT_TAG_LO + TAG_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  cfr_item_t         item,
    output logic              res_valid,
    input  logic              res_ready,
    output cfr_result_t       res,
    output logic              mem_rd_en,
    output logic [SLOT_W-1:0] mem_rd_addr,
    input  logic [ENT_W-1:0]  mem_rd_data,
    output logic              mem_wr_en,
    output logic [SLOT_W-1:0] mem_wr_addr,
    output logic [ENT_W-1:0]  mem_wr_data
);

    localparam int IDX_EXT_W = (SLOT_W > IDX_W) ? SLOT_W : IDX_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(FRAME_COUNT - 1);
    localparam logic [SLOT_W:0] FULL_COUNT = (SLOT_W + 1)'(FRAME_COUNT);
    localparam logic [SLOT_W:0] LAST_STEP = (SLOT_W + 1)'(2 * FRAME_COUNT - 1);
    localparam logic [31:0] FRAME_LIMIT = 32'(FRAME_COUNT);

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] n;
        n = (s == LAST_SLOT) ? '0 : s + 1'b1;
        return n;
    endfunction

    state_t              state_reg, state_next;
    logic [SLOT_W-1:0]   clr_reg, clr_next;
    logic [SLOT_W:0]     step_reg, step_next;
    logic [SLOT_W-1:0]   hand_reg, hand_next;
    logic [SLOT_W:0]     count_reg, count_next;
    logic [SLOT_W-1:0]   look_reg, look_next;
    cmd_t                cmd_reg, cmd_next;
    logic [TAG_BITS-1:0] tag_reg, tag_next;
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic                wr_reg, wr_next;
    logic                pin_reg, pin_next;
    cfr_result_t         res_reg, res_next;

    logic [IDX_EXT_W-1:0] idx_ext;
    logic [SLOT_W-1:0]    idx_slot;
    logic                 idx_in_range;
    logic                 table_full;
    logic                 e_valid, e_accessed, e_dirty, e_pinned;
    logic [KIND_W-1:0]    e_kind;
    logic [TAG_BITS-1:0]  e_tag;
    logic                 scan_found, sweep_hit, sweep_last;
    logic [ENT_W-1:0]     fill_entry;

    assign idx_ext      = IDX_EXT_W'(item.frame_index);
    assign idx_slot     = idx_ext[SLOT_W-1:0];
    assign idx_in_range = (32'(item.frame_index) < FRAME_LIMIT);
    assign table_full   = (count_reg == FULL_COUNT);

    assign e_valid    = mem_rd_data[ENT_VALID];
    assign e_accessed = mem_rd_data[ENT_ACCESSED];
    assign e_dirty    = mem_rd_data[ENT_DIRTY];
    assign e_pinned   = mem_rd_data[ENT_PINNED];
    assign e_kind     = mem_rd_data[ENT_KIND_LO +: KIND_W];
    assign e_tag      = mem_rd_data[ENT_TAG_LO +: TAG_BITS];

    assign scan_found = !e_valid;
    assign sweep_hit  = !e_pinned && !e_accessed;
    assign sweep_last = (step_reg == LAST_STEP);

    always_comb
    begin
        fill_entry = '0;
        fill_entry[ENT_VALID] = 1'b1;
        fill_entry[ENT_KIND_LO +: KIND_W] = kind_reg;
        fill_entry[ENT_TAG_LO +: TAG_BITS] = tag_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == LAST_SLOT)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (item_valid)
                begin
                    if (item.command == CMD_ALLOC)
                    begin
                        state_next = table_full ? S_SWEEP : S_SCAN;
                    end
                    else
                    begin
                        state_next = idx_in_range ? S_TARGET : S_DELIVER;
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_found)
                begin
                    state_next = S_DELIVER;
                end
            end
            S_SWEEP:
            begin
                if (sweep_hit || sweep_last)
                begin
                    state_next = S_DELIVER;
                end
            end
            S_TARGET:
            begin
                state_next = S_DELIVER;
            end
            S_DELIVER:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        clr_next    = clr_reg;
        step_next   = step_reg;
        hand_next   = hand_reg;
        count_next  = count_reg;
        look_next   = look_reg;
        cmd_next    = cmd_reg;
        tag_next    = tag_reg;
        kind_next   = kind_reg;
        wr_next     = wr_reg;
        pin_next    = pin_reg;
        res_next    = res_reg;
        item_ready  = 1'b0;
        res_valid   = 1'b0;
        mem_rd_en   = 1'b0;
        mem_rd_addr = look_reg;
        mem_wr_en   = 1'b0;
        mem_wr_addr = look_reg;
        mem_wr_data = mem_rd_data;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = clr_reg;
                mem_wr_data = '0;
                clr_next    = clr_reg + 1'b1;
            end
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd_next  = item.command;
                    tag_next  = TAG_BITS'(item.page_tag);
                    kind_next = item.page_kind;
                    wr_next   = item.is_write;
                    pin_next  = item.pin_value;
                    res_next  = '0;
                    if (item.command == CMD_ALLOC)
                    begin
                        mem_rd_en = 1'b1;
                        step_next = '0;
                        if (table_full)
                        begin
                            mem_rd_addr = hand_reg;
                            look_next   = hand_reg;
                        end
                        else
                        begin
                            mem_rd_addr = '0;
                            look_next   = '0;
                        end
                    end
                    else if (idx_in_range)
                    begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = idx_slot;
                        look_next   = idx_slot;
                    end
                    else
                    begin
                        res_next.status = STAT_NOT_VALID;
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_found)
                begin
                    mem_wr_en              = 1'b1;
                    mem_wr_data            = fill_entry;
                    res_next.granted_frame = IDX_W'(look_reg);
                    count_next             = count_reg + 1'b1;
                end
                else
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = next_slot(look_reg);
                    look_next   = next_slot(look_reg);
                end
            end
            S_SWEEP:
            begin
                if (sweep_hit)
                begin
                    mem_wr_en              = 1'b1;
                    mem_wr_data            = fill_entry;
                    res_next.granted_frame = IDX_W'(look_reg);
                    res_next.evicted       = 1'b1;
                    res_next.evicted_tag   = PTAG_W'(e_tag);
                    res_next.write_back    = (e_kind == KIND_ANON) ||
                                             ((e_kind == KIND_BIN) && e_dirty);
                    hand_next              = next_slot(look_reg);
                end
                else
                begin
                    mem_wr_en = e_accessed;
                    mem_wr_data[ENT_ACCESSED] = 1'b0;
                    if (sweep_last)
                    begin
                        res_next.status = STAT_ALL_PINNED;
                    end
                    else
                    begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = next_slot(look_reg);
                        look_next   = next_slot(look_reg);
                        step_next   = step_reg + 1'b1;
                    end
                end
            end
            S_TARGET:
            begin
                if (!e_valid)
                begin
                    res_next.status = STAT_NOT_VALID;
                end
                else
                begin
                    unique case (cmd_reg)
                        CMD_FREE:
                        begin
                            mem_wr_en = 1'b1;
                            mem_wr_data[ENT_VALID]    = 1'b0;
                            mem_wr_data[ENT_ACCESSED] = 1'b0;
                            mem_wr_data[ENT_DIRTY]    = 1'b0;
                            mem_wr_data[ENT_PINNED]   = 1'b0;
                            count_next = count_reg - 1'b1;
                        end
                        CMD_REF:
                        begin
                            mem_wr_en = 1'b1;
                            mem_wr_data[ENT_ACCESSED] = 1'b1;
                            mem_wr_data[ENT_DIRTY]    = e_dirty | wr_reg;
                        end
                        CMD_PIN:
                        begin
                            mem_wr_en = 1'b1;
                            mem_wr_data[ENT_PINNED] = pin_reg;
                        end
                        CMD_ALLOC:
                        begin
                            mem_wr_en = 1'b0;
                        end
                    endcase
                end
            end
            S_DELIVER:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    assign res = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            step_reg  <= '0;
            hand_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            step_reg  <= step_next;
            hand_reg  <= hand_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        look_reg <= look_next;
        cmd_reg  <= cmd_next;
        tag_reg  <= tag_next;
        kind_reg <= kind_next;
        wr_reg   <= wr_next;
        pin_reg  <= pin_next;
        res_reg  <= res_next;
    end

endmodule

FILE: rtl/cfr_out_stage.sv
// Output register that holds one result item until the downstream side takes it.
module cfr_out_stage
    import cfr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                res_valid,
    output logic                res_ready,
    input  cfr_result_t         res,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [M_DATA_W-1:0] m_axis_tdata,
    output logic [STATUS_W-1:0] m_axis_tuser
);

    logic        valid_reg, valid_next;
    cfr_result_t out_reg, out_next;

    assign res_ready = !valid_reg || m_axis_tready;

    always_comb
    begin
        valid_next = valid_reg;
        out_next   = out_reg;
        if (res_ready)
        begin
            valid_next = res_valid;
            if (res_valid)
            begin
                out_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {{(M_DATA_W - OUT_USED_W){1'b0}}, out_reg.write_back,
                            out_reg.evicted_tag, out_reg.evicted, out_reg.granted_frame};
    assign m_axis_tuser  = out_reg.status;

endmodule

FILE: rtl/clock_frame_replacement.sv
// Top level of the frame table with clock (second chance) replacement.
//
// The slot table lives in one RAM with a registered read, one entry per
// frame, and every command is a read, modify and write of that RAM. After
// reset a clearing pass writes every entry once, and no item is taken until
// it ends. Free, reference and pin work on the target slot; when the target
// index lies at or beyond FRAME_COUNT no RAM read is needed and the status
// is not valid. Allocate reads one slot per cycle through the RAM read port:
// with a free slot it takes the lowest free slot; with the table full the
// clock hand passes one slot per cycle and ends with status all pinned after
// two full turns when every frame is pinned. In each case the result is
// loaded into the output register as the sequencer returns to idle, and a
// stalled output register holds the block until it is free. One item is
// worked on at a time; a finished result waits in the output register while
// the next item is taken.
module clock_frame_replacement
    import cfr_pkg::*;
#(
    parameter int FRAME_COUNT = 64,
    parameter int TAG_BITS = 20
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // frame_index, page_tag, page_kind, is_write, pin_value, zero fill
    input  logic [S_DATA_W-1:0] s_axis_tdata,
    // command
    input  logic [CMD_W-1:0]    s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // granted_frame, evicted, evicted_tag, write_back, zero fill
    output logic [M_DATA_W-1:0] m_axis_tdata,
    // status
    output logic [STATUS_W-1:0] m_axis_tuser
);

    localparam int SLOT_W = $clog2(FRAME_COUNT);
    localparam int ENT_W = ENT_TAG_LO + TAG_BITS;

    cfr_item_t         item;
    cfr_result_t       res;
    logic              res_valid;
    logic              res_ready;
    logic              mem_rd_en;
    logic [SLOT_W-1:0] mem_rd_addr;
    logic [ENT_W-1:0]  mem_rd_data;
    logic              mem_wr_en;
    logic [SLOT_W-1:0] mem_wr_addr;
    logic [ENT_W-1:0]  mem_wr_data;

    assign item.command     = cmd_t'(s_axis_tuser);
    assign item.frame_index = s_axis_tdata[IN_IDX_LO +: IDX_W];
    assign item.page_tag    = s_axis_tdata[IN_TAG_LO +: PTAG_W];
    assign item.page_kind   = s_axis_tdata[IN_KIND_LO +: KIND_W];
    assign item.is_write    = s_axis_tdata[IN_WRITE_BIT];
    assign item.pin_value   = s_axis_tdata[IN_PIN_BIT];

    cfr_ctrl #(
        .FRAME_COUNT (FRAME_COUNT),
        .TAG_BITS    (TAG_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (s_axis_tvalid),
        .item_ready  (s_axis_tready),
        .item        (item),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data)
    );

    cfr_ram #(
        .WIDTH (ENT_W),
        .DEPTH (FRAME_COUNT)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    cfr_out_stage u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

FILE: rtl/cfr_checker.sv
// Port-level checks for the frame table, attached to the top level.
module cfr_checker
    import cfr_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_axis_tvalid,
    input logic                s_axis_tready,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [M_DATA_W-1:0] m_axis_tdata,
    input logic [STATUS_W-1:0] m_axis_tuser
);

    // Items are handled one at a time, so the input closes right after a take.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after an accepted item");

    // A failed command grants nothing and evicts nothing.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != STAT_OK) |-> (m_axis_tdata == '0))
        else $error("failed command carries a grant or an eviction");

    // Without an eviction there is no old tag and no write-back.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[OUT_EVICTED_BIT]
            |-> (m_axis_tdata[M_DATA_W-1:OUT_TAG_LO] == '0))
        else $error("tag or write-back without an eviction");

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready
            |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

endmodule

bind clock_frame_replacement cfr_checker u_cfr_checker (.*);
